@@ hdl/bda_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bda_pkg: shared types and constants
// Widths, sequencer states and converter status for the binary to decimal
// ASCII core.
// ---------------------------------------------------------------------------
package bda_pkg;

	// input number width
	localparam int NUMBER_BITS = 32;
	// floor(NUMBER_BITS * log10(2)) + 1, with log10(2) ~ 1233/4096
	localparam int NUM_DIGITS  = ((NUMBER_BITS * 1233) / 4096) + 1;
	localparam int BCD_W       = 4 * NUM_DIGITS;
	localparam int STEP_W      = $clog2(NUMBER_BITS);
	localparam int CNT_W       = $clog2(NUM_DIGITS + 1);
	localparam int IN_TDATA_W  = ((NUMBER_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;

	// upper two bits of an ASCII digit ('0' = 6'b11_0000)
	localparam logic [1:0] ASCII_DIGIT_HI = 2'b11;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} conv_status_t;

endpackage
`default_nettype wire

@@ hdl/bda_convert.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bda_convert: iterative shift-and-add-3 converter
// One add-3 / shift unit, applied once per input bit, turns a binary value
// into packed BCD.
// ---------------------------------------------------------------------------
module bda_convert (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [bda_pkg::NUMBER_BITS-1:0] number,
	output bda_pkg::conv_status_t                status,
	output logic      [bda_pkg::BCD_W-1:0]       bcd
);
	import bda_pkg::*;

	logic [NUMBER_BITS-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_adj;
	logic [STEP_W-1:0]      step_q;
	logic                   busy_q;
	logic                   done_q;

	// add 3 to every digit that is 5 or more
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUMBER_BITS - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= number;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[NUMBER_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[NUMBER_BITS-1]};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign bcd         = bcd_q;

endmodule
`default_nettype wire

@@ hdl/binary_to_decimal_ascii_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii_core: unsigned binary to decimal ASCII stream
// Converts one unsigned number per request into its decimal digits as
// ASCII characters, most significant first, leading zeros suppressed.
// ---------------------------------------------------------------------------
// Usage:
//   s_tdata[31:0] carries the number. A request is taken when s_tvalid and
//   s_tready are both high; s_tready is high only while the core is idle.
//   m_tdata[5:0] carries digit_char ('0'..'9'), m_tdata[7:6] are zero, and
//   m_tlast marks the least significant digit. Zero yields one '0'.
// Sequence:
//   After acceptance the shift-and-add-3 unit runs NUMBER_BITS (32) shifts,
//   then the sequencer skips leading zero digits one at a time (up to 9)
//   until it finds the first digit, then one digit leaves per cycle while
//   m_tready is high. A new request is accepted only after the last digit
//   has gone out and the core is idle again.
// Reset:
//   arst_n clears the sequencer; the core comes up idle with no output.
// Stalls:
//   A digit is held stable on m_tdata until taken; no new request is
//   accepted until the last digit of the current number has gone out.
// ---------------------------------------------------------------------------
module binary_to_decimal_ascii_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// s_tdata: number[NUMBER_BITS-1:0], zero padding above
	input  wire logic [bda_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// m_tdata: digit_char[5:0], zero padding [7:6]
	output logic      [bda_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// m_tlast: last_digit
	output logic                                 m_tlast
);
	import bda_pkg::*;

	state_t             state_q;
	state_t             state_nxt;
	logic [BCD_W-1:0]   digits_q;   // top nibble is the next digit out
	logic [CNT_W-1:0]   left_q;     // digits still to emit or skip
	logic               conv_start;
	conv_status_t       conv_status;
	logic [BCD_W-1:0]   conv_bcd;
	logic [3:0]         top_digit;
	logic               s_fire;
	logic               m_fire;

	assign top_digit = digits_q[BCD_W-1 -: 4];
	assign s_fire    = s_tvalid && s_tready;
	assign m_fire    = m_tvalid && m_tready;

	bda_convert u_convert (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.number (s_tdata[NUMBER_BITS-1:0]),
		.status (conv_status),
		.bcd    (conv_bcd)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) state_nxt = ST_CONV;
			end
			ST_CONV: begin
				if (conv_status.done) state_nxt = ST_SKIP;
			end
			ST_SKIP: begin
				// strip leading zeros, keep at least one digit
				if (top_digit != 4'd0 || left_q == CNT_W'(1)) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (m_fire && left_q == CNT_W'(1)) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready   = 1'b0;
		m_tvalid   = 1'b0;
		conv_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				conv_start = s_tvalid;
			end
			ST_EMIT: begin
				m_tvalid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign m_tdata = {2'b00, ASCII_DIGIT_HI, top_digit};
	assign m_tlast = (left_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CONV && conv_status.done) begin
				left_q <= CNT_W'(NUM_DIGITS);
			end else if (state_q == ST_SKIP && state_nxt == ST_SKIP) begin
				left_q <= left_q - 1'b1;
			end else if (m_fire) begin
				left_q <= left_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CONV && conv_status.done) begin
			digits_q <= conv_bcd;
		end else if ((state_q == ST_SKIP && state_nxt == ST_SKIP) || m_fire) begin
			digits_q <= {digits_q[BCD_W-5:0], 4'd0};
		end
	end

	// never take a request while a digit is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while output valid");

	// an accepted request starts the converter
	a_start_conv: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (state_q == ST_CONV && conv_status.busy))
		else $error("converter not started after request");

	// emitted digits are decimal
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (top_digit <= 4'd9))
		else $error("non-decimal digit emitted");

	// converter finishes only while the sequencer waits for it
	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		conv_status.done |-> (state_q == ST_CONV))
		else $error("converter done outside conversion");

endmodule
`default_nettype wire
